// ----- hdl/vdg_pkg.sv -----
`default_nettype none

package vdg_pkg;

  localparam int NUM_PIX = 8;

  typedef logic [3:0] colour_t;

  localparam colour_t COL_BLACK   = 4'd0;
  localparam colour_t COL_GREEN   = 4'd1;
  localparam colour_t COL_BASE_S0 = 4'd1;
  localparam colour_t COL_BASE_S1 = 4'd5;

  localparam logic [1:0] REG_GRAPHICS_SELECT = 2'd0;
  localparam logic [1:0] REG_GRAPHICS_MODE   = 2'd1;
  localparam logic [1:0] REG_COLOUR_SET      = 2'd2;

  localparam logic [2:0] GMODE_LOWEST  = 3'd0;
  localparam logic [2:0] GMODE_HIGHEST = 3'd7;

  localparam logic [3:0] COUNT_2 = 4'd2;
  localparam logic [3:0] COUNT_4 = 4'd4;
  localparam logic [3:0] COUNT_8 = 4'd8;

  localparam logic [2:0] REP_1 = 3'd1;
  localparam logic [2:0] REP_2 = 3'd2;
  localparam logic [2:0] REP_4 = 3'd4;

  typedef enum logic [1:0] {
    MODE_ALPHA = 2'd0,
    MODE_SEMI  = 2'd1,
    MODE_GFX4  = 2'd2,
    MODE_RES   = 2'd3
  } mode_t;

endpackage

`default_nettype wire

// ----- hdl/vdg_character_slot_pixel_decoder_unit.sv -----
`default_nettype none

// Decodes one character slot per beat into up to eight pixel colour codes, the
// pixel count and the horizontal repeat. A beat is taken in every cycle unless
// in_stall is high, and passes three register stages (input capture and mode
// decode, pixel lit mask and colour select, colour code build). out_stall holds
// the whole pipeline only where it is full, so empty stages keep filling behind
// a waiting result. The mode registers are written through the cfg port and
// should only change while no beat is in flight.
module vdg_character_slot_pixel_decoder_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire [1:0]          cfg_index,
  input  wire [2:0]          cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire [7:0]          in_mem_byte,
  input  wire [7:0]          in_rom_row,
  input  wire [3:0]          in_cell_row,
  input  wire                in_semigraphic_select,
  input  wire                in_invert,
  output logic               out_valid,
  input  wire                out_stall,
  output vdg_pkg::colour_t   out_pix_a,
  output vdg_pkg::colour_t   out_pix_b,
  output vdg_pkg::colour_t   out_pix_c,
  output vdg_pkg::colour_t   out_pix_d,
  output vdg_pkg::colour_t   out_pix_e,
  output vdg_pkg::colour_t   out_pix_f,
  output vdg_pkg::colour_t   out_pix_g,
  output vdg_pkg::colour_t   out_pix_h,
  output logic [3:0]         out_pixel_count,
  output logic [2:0]         out_pixel_repeat
);
  import vdg_pkg::*;

  // configuration
  logic       gsel_r;
  logic [2:0] gmode_r;
  logic       cset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gsel_r  <= 1'b0;
      gmode_r <= 3'd0;
      cset_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRAPHICS_SELECT: gsel_r  <= cfg_data[0];
        REG_GRAPHICS_MODE:   gmode_r <= cfg_data;
        REG_COLOUR_SET:      cset_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage advance chain
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic adv0, adv1, adv2;

  assign adv2     = !out_valid_r || !out_stall;
  assign adv1     = !s2_valid_r || adv2;
  assign adv0     = !s1_valid_r || adv1;
  assign in_stall = !adv0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv0) s1_valid_r  <= in_valid;
      if (adv1) s2_valid_r  <= s1_valid_r;
      if (adv2) out_valid_r <= s2_valid_r;
    end
  end

  // stage 1: capture and mode decode
  mode_t      s1_mode_r, s1_mode_nxt;
  logic [2:0] s1_gmode_r;
  logic       s1_cset_r;
  logic [7:0] s1_mem_r;
  logic [7:0] s1_dots_r, s1_dots_nxt;
  logic [1:0] s1_brow_r, s1_brow_nxt;

  always_comb begin
    if (gsel_r) begin
      s1_mode_nxt = gmode_r[0] ? MODE_RES : MODE_GFX4;
    end else begin
      s1_mode_nxt = in_semigraphic_select ? MODE_SEMI : MODE_ALPHA;
    end
    s1_dots_nxt = in_rom_row ^ {8{in_invert}};
    // rows twelve and up fold into the bottom block row
    s1_brow_nxt = (in_cell_row[3:2] == 2'd3) ? 2'd2 : in_cell_row[3:2];
  end

  always_ff @(posedge clk) begin
    if (adv0 && in_valid) begin
      s1_mode_r  <= s1_mode_nxt;
      s1_gmode_r <= gmode_r;
      s1_cset_r  <= cset_r;
      s1_mem_r   <= in_mem_byte;
      s1_dots_r  <= s1_dots_nxt;
      s1_brow_r  <= s1_brow_nxt;
    end
  end

  // stage 2: lit mask and colour selectors, pixel 0 leftmost
  logic [NUM_PIX-1:0] s2_lit_r, s2_lit_nxt;
  logic [1:0]         s2_sel_r [NUM_PIX];
  logic [1:0]         s2_sel_nxt [NUM_PIX];
  logic               s2_pal_r, s2_pal_nxt;
  logic               s2_cset_r;
  logic [3:0]         s2_count_r, s2_count_nxt;
  logic [2:0]         s2_rep_r, s2_rep_nxt;
  logic [1:0]         semi_bits;

  always_comb begin
    s2_lit_nxt   = '0;
    s2_pal_nxt   = 1'b0;
    s2_count_nxt = COUNT_8;
    s2_rep_nxt   = REP_1;
    for (int i = 0; i < NUM_PIX; i++) begin
      s2_sel_nxt[i] = s1_mem_r[7:6];
    end
    case (s1_brow_r)
      2'd0:    semi_bits = s1_mem_r[5:4];
      2'd1:    semi_bits = s1_mem_r[3:2];
      default: semi_bits = s1_mem_r[1:0];
    endcase
    case (s1_mode_r)
      MODE_ALPHA: begin
        for (int i = 0; i < NUM_PIX; i++) begin
          s2_lit_nxt[i] = s1_dots_r[NUM_PIX-1-i];
        end
      end
      MODE_RES: begin
        for (int i = 0; i < NUM_PIX; i++) begin
          s2_lit_nxt[i] = s1_mem_r[NUM_PIX-1-i];
        end
        s2_rep_nxt = (s1_gmode_r == GMODE_HIGHEST) ? REP_1 : REP_2;
      end
      MODE_GFX4: begin
        for (int i = 0; i < 4; i++) begin
          s2_lit_nxt[i] = 1'b1;
          s2_sel_nxt[i] = s1_mem_r[6-2*i +: 2];
        end
        s2_pal_nxt   = 1'b1;
        s2_count_nxt = COUNT_4;
        s2_rep_nxt   = (s1_gmode_r == GMODE_LOWEST) ? REP_4 : REP_2;
      end
      MODE_SEMI: begin
        s2_lit_nxt[0] = semi_bits[1];
        s2_lit_nxt[1] = semi_bits[0];
        s2_pal_nxt    = 1'b1;
        s2_count_nxt  = COUNT_2;
        s2_rep_nxt    = REP_4;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv1 && s1_valid_r) begin
      s2_lit_r   <= s2_lit_nxt;
      s2_sel_r   <= s2_sel_nxt;
      s2_pal_r   <= s2_pal_nxt;
      s2_cset_r  <= s1_cset_r;
      s2_count_r <= s2_count_nxt;
      s2_rep_r   <= s2_rep_nxt;
    end
  end

  // stage 3: colour codes
  colour_t    pix_r [NUM_PIX];
  colour_t    pix_nxt [NUM_PIX];
  colour_t    pal_base;
  logic [3:0] count_r;
  logic [2:0] rep_r;

  always_comb begin
    pal_base = s2_cset_r ? COL_BASE_S1 : COL_BASE_S0;
    for (int i = 0; i < NUM_PIX; i++) begin
      if (!s2_lit_r[i]) begin
        pix_nxt[i] = COL_BLACK;
      end else if (s2_pal_r) begin
        pix_nxt[i] = pal_base + {2'b00, s2_sel_r[i]};
      end else begin
        pix_nxt[i] = COL_GREEN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s2_valid_r) begin
      pix_r   <= pix_nxt;
      count_r <= s2_count_r;
      rep_r   <= s2_rep_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pix_a        = pix_r[0];
  assign out_pix_b        = pix_r[1];
  assign out_pix_c        = pix_r[2];
  assign out_pix_d        = pix_r[3];
  assign out_pix_e        = pix_r[4];
  assign out_pix_f        = pix_r[5];
  assign out_pix_g        = pix_r[6];
  assign out_pix_h        = pix_r[7];
  assign out_pixel_count  = count_r;
  assign out_pixel_repeat = rep_r;

`ifndef SYNTH
  a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pixel_count == COUNT_2 || out_pixel_count == COUNT_4 ||
                   out_pixel_count == COUNT_8))
    else $error("illegal pixel count");

  a_unused_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel_count != COUNT_8) |->
      (out_pix_e == COL_BLACK && out_pix_f == COL_BLACK &&
       out_pix_g == COL_BLACK && out_pix_h == COL_BLACK))
    else $error("unused pixel not black");

  a_semi_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pixel_count == COUNT_2) |->
      (out_pixel_repeat == REP_4 && out_pix_c == COL_BLACK && out_pix_d == COL_BLACK))
    else $error("semigraphics beat malformed");

  a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s2_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in pipeline");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import vdg_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [7:0] mem;
    logic [7:0] rom;
    logic [3:0] crow;
    logic       semi;
    logic       inv;
  } slot_t;

  typedef struct packed {
    colour_t [0:7] pix;
    logic [3:0]    count;
    logic [2:0]    rep;
  } pix_res_t;

  typedef struct packed {
    logic       wr;
    logic [1:0] wr_idx;
    logic [2:0] wr_data;
    slot_t      s;
    logic       typed;
    pix_res_t   res;
  } vec_t;

  localparam pix_res_t NO_RES = '0;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [2:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic [7:0] in_mem_byte;
  logic [7:0] in_rom_row;
  logic [3:0] in_cell_row;
  logic in_semigraphic_select;
  logic in_invert;
  logic out_valid;
  logic out_stall;
  colour_t out_pix_a, out_pix_b, out_pix_c, out_pix_d;
  colour_t out_pix_e, out_pix_f, out_pix_g, out_pix_h;
  logic [3:0] out_pixel_count;
  logic [2:0] out_pixel_repeat;

  // mirrored mode registers
  logic       gfx_sel;
  logic [2:0] gfx_mode;
  logic       col_set;

  pix_res_t slot_pix_q [$];
  int err_cnt;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  int quiet_cycles;

  vec_t dir_tab [22] = '{
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'h00, 8'hff, 4'd0, 1'b0, 1'b0},
      1'b1, '{32'h11111111, COUNT_8, REP_1}},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'hff, 8'h00, 4'd0, 1'b0, 1'b0},
      1'b1, '{32'h00000000, COUNT_8, REP_1}},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'h00, 8'h00, 4'd0, 1'b0, 1'b1},
      1'b1, '{32'h11111111, COUNT_8, REP_1}},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'h5a, 8'ha5, 4'd3, 1'b0, 1'b1}, 1'b0, NO_RES},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'h00, 8'h00, 4'd0, 1'b1, 1'b0},
      1'b1, '{32'h00000000, COUNT_2, REP_4}},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'hff, 8'h00, 4'd0, 1'b1, 1'b0},
      1'b1, '{32'h44000000, COUNT_2, REP_4}},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'hb4, 8'h00, 4'd4, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'h6c, 8'h00, 4'd11, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'he7, 8'h00, 4'd15, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'h93, 8'h00, 4'd12, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{1'b1, REG_COLOUR_SET, 3'd1, '{8'hff, 8'h00, 4'd0, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{1'b1, REG_GRAPHICS_SELECT, 3'd1, '{8'h00, 8'h00, 4'd0, 1'b0, 1'b0},
      1'b1, '{32'h55550000, COUNT_4, REP_4}},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'hff, 8'h00, 4'd0, 1'b0, 1'b0},
      1'b1, '{32'h88880000, COUNT_4, REP_4}},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'h1b, 8'hff, 4'd7, 1'b1, 1'b1}, 1'b0, NO_RES},
    '{1'b1, REG_GRAPHICS_MODE, GMODE_HIGHEST, '{8'hff, 8'h00, 4'd0, 1'b0, 1'b0},
      1'b1, '{32'h11111111, COUNT_8, REP_1}},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'h00, 8'hff, 4'd0, 1'b0, 1'b0},
      1'b1, '{32'h00000000, COUNT_8, REP_1}},
    '{1'b0, REG_GRAPHICS_SELECT, 3'd0, '{8'hc3, 8'h00, 4'd2, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{1'b1, REG_GRAPHICS_MODE, 3'd1, '{8'ha5, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{1'b1, REG_GRAPHICS_MODE, 3'd6, '{8'he4, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{1'b1, REG_COLOUR_SET, 3'b110, '{8'he4, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{1'b1, REG_UNUSED, 3'd7, '{8'he4, 8'h00, 4'd0, 1'b0, 1'b0}, 1'b0, NO_RES},
    '{1'b1, REG_GRAPHICS_SELECT, 3'b110, '{8'h00, 8'h3c, 4'd0, 1'b0, 1'b1}, 1'b0, NO_RES}
  };

  vdg_character_slot_pixel_decoder_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_mem_byte(in_mem_byte),
    .in_rom_row(in_rom_row),
    .in_cell_row(in_cell_row),
    .in_semigraphic_select(in_semigraphic_select),
    .in_invert(in_invert),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_pix_a(out_pix_a),
    .out_pix_b(out_pix_b),
    .out_pix_c(out_pix_c),
    .out_pix_d(out_pix_d),
    .out_pix_e(out_pix_e),
    .out_pix_f(out_pix_f),
    .out_pix_g(out_pix_g),
    .out_pix_h(out_pix_h),
    .out_pixel_count(out_pixel_count),
    .out_pixel_repeat(out_pixel_repeat)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic colour_t palette_pick(logic [1:0] sel);
    colour_t base;
    base = col_set ? COL_BASE_S1 : COL_BASE_S0;
    return colour_t'(base + sel);
  endfunction

  function automatic pix_res_t decode_slot(slot_t s);
    pix_res_t r;
    mode_t m;
    logic [7:0] dots;
    logic [3:0] brow;
    logic [1:0] bits;
    r = '0;
    if (gfx_sel) begin
      m = gfx_mode[0] ? MODE_RES : MODE_GFX4;
    end else begin
      m = s.semi ? MODE_SEMI : MODE_ALPHA;
    end
    case (m)
      MODE_ALPHA: begin
        dots = s.inv ? ~s.rom : s.rom;
        for (int i = 0; i < 8; i++) r.pix[i] = dots[7-i] ? COL_GREEN : COL_BLACK;
        r.count = COUNT_8;
        r.rep = REP_1;
      end
      MODE_SEMI: begin
        brow = s.crow / 4;
        if (brow > 2) brow = 2;
        bits = 2'((s.mem[5:0] >> (2 * (2 - brow))) & 6'h3);
        r.pix[0] = bits[1] ? palette_pick(s.mem[7:6]) : COL_BLACK;
        r.pix[1] = bits[0] ? palette_pick(s.mem[7:6]) : COL_BLACK;
        r.count = COUNT_2;
        r.rep = REP_4;
      end
      MODE_GFX4: begin
        for (int i = 0; i < 4; i++) r.pix[i] = palette_pick(s.mem[7-2*i -: 2]);
        r.count = COUNT_4;
        r.rep = (gfx_mode == GMODE_LOWEST) ? REP_4 : REP_2;
      end
      default: begin
        for (int i = 0; i < 8; i++) r.pix[i] = s.mem[7-i] ? COL_GREEN : COL_BLACK;
        r.count = COUNT_8;
        r.rep = (gfx_mode == GMODE_HIGHEST) ? REP_1 : REP_2;
      end
    endcase
    return r;
  endfunction

  function automatic slot_t rand_slot();
    slot_t s;
    s.mem = 8'($urandom_range(255));
    s.rom = 8'($urandom_range(255));
    s.crow = 4'($urandom_range(15));
    s.semi = 1'($urandom_range(1));
    s.inv = 1'($urandom_range(1));
    return s;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("tb: mismatch on %s at %0t: got %0h want %0h", field, $realtime, got, want);
    err_cnt++;
  endtask

  task automatic send_beat(slot_t s, logic typed, pix_res_t want);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mem_byte <= s.mem;
    in_rom_row <= s.rom;
    in_cell_row <= s.crow;
    in_semigraphic_select <= s.semi;
    in_invert <= s.inv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    slot_pix_q.push_back(typed ? want : decode_slot(s));
  endtask

  // wait until every beat in flight has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (slot_pix_q.size() != 0);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [2:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_GRAPHICS_SELECT: gfx_sel = data[0];
      REG_GRAPHICS_MODE:   gfx_mode = data;
      REG_COLOUR_SET:      col_set = data[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver stall, with a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    pix_res_t got;
    pix_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.pix = {out_pix_a, out_pix_b, out_pix_c, out_pix_d,
                 out_pix_e, out_pix_f, out_pix_g, out_pix_h};
      got.count = out_pixel_count;
      got.rep = out_pixel_repeat;
      if (slot_pix_q.size() == 0) begin
        report_mismatch("unexpected beat", 32'(got.pix), 0);
      end else begin
        want = slot_pix_q.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (got.pix[i] !== want.pix[i])
            report_mismatch($sformatf("pix %0d", i), 32'(got.pix[i]), 32'(want.pix[i]));
        end
        if (got.count !== want.count)
          report_mismatch("pixel_count", 32'(got.count), 32'(want.count));
        if (got.rep !== want.rep)
          report_mismatch("pixel_repeat", 32'(got.rep), 32'(want.rep));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    err_cnt = 0;
    quiet_cycles = 0;
    hold_req = 1'b0;
    send_idle_pct = 22;
    recv_idle_pct = 66;
    gfx_sel = 1'b0;
    gfx_mode = 3'd0;
    col_set = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 2'd0;
    cfg_data = 3'd0;
    in_valid = 1'b0;
    in_mem_byte = 8'd0;
    in_rom_row = 8'd0;
    in_cell_row = 4'd0;
    in_semigraphic_select = 1'b0;
    in_invert = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[k]) begin
      if (dir_tab[k].wr) begin
        drain();
        cfg_write(dir_tab[k].wr_idx, dir_tab[k].wr_data);
      end
      send_beat(dir_tab[k].s, dir_tab[k].typed, dir_tab[k].res);
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 66 : 0;
      recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 22 : 0;
      if (ph == 2) begin
        // receiver holds off while beats keep coming, so the pipe backs up
        drain();
        hold_req = 1'b1;
        repeat (40) send_beat(rand_slot(), 1'b0, NO_RES);
      end
      for (int seg = 0; seg < 6; seg++) begin
        drain();
        cfg_write(REG_GRAPHICS_SELECT, 3'($urandom_range(7)));
        cfg_write(REG_GRAPHICS_MODE, 3'($urandom_range(7)));
        cfg_write(REG_COLOUR_SET, 3'($urandom_range(7)));
        if ($urandom_range(3) == 0) cfg_write(REG_UNUSED, 3'($urandom_range(7)));
        repeat (55) send_beat(rand_slot(), 1'b0, NO_RES);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
